// ===== hw/rtl/kmc_pkg.sv =====
package kmc_pkg;

   // Depth of the folded byte history kept in the cell chain.
   localparam int HISTORY_DEPTH = 11;

   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [7:0] FOLD_BIT  = 8'h20;

   localparam int NUM_PREFIX     = 5;
   localparam int PREFIX_MAX_LEN = 5;
   localparam int NUM_KEYS       = 25;
   localparam int KEY_MAX_LEN    = 12;
   localparam int NUM_GROUPS     = 6;

   localparam logic [6:0] CONF_UNKNOWN   = 7'd0;
   localparam logic [6:0] CONF_DEFAULT   = 7'd80;
   localparam logic [6:0] CONF_EMOTIONAL = 7'd75;
   localparam logic [6:0] CONF_CASUAL    = 7'd60;

   typedef enum logic [2:0] {
      GROUP_INFO      = 3'd0,
      GROUP_QUESTION  = 3'd1,
      GROUP_URGENT    = 3'd2,
      GROUP_EMOTIONAL = 3'd3,
      GROUP_PLANNING  = 3'd4,
      GROUP_HUMOR     = 3'd5
   } group_type;

   typedef enum logic [3:0] {
      CLASS_UNKNOWN   = 4'd0,
      CLASS_GREETING  = 4'd1,
      CLASS_INFO      = 4'd2,
      CLASS_QUESTION  = 4'd3,
      CLASS_URGENT    = 4'd4,
      CLASS_EMOTIONAL = 4'd5,
      CLASS_PLANNING  = 4'd6,
      CLASS_HUMOR     = 4'd7,
      CLASS_CASUAL    = 4'd8
   } class_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      class_type  class_code;
      logic [6:0] confidence_pct;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // Greeting prefixes, first character first.
   localparam logic [7:0] PREFIX_CHAR [NUM_PREFIX][PREFIX_MAX_LEN] = '{
      '{"h", "e", "y", 8'h00, 8'h00},
      '{"h", "i", 8'h00, 8'h00, 8'h00},
      '{"h", "e", "l", "l", "o"},
      '{"y", "o", 8'h00, 8'h00, 8'h00},
      '{"s", "u", "p", 8'h00, 8'h00}
   };
   localparam int PREFIX_LEN [NUM_PREFIX] = '{3, 2, 5, 2, 3};

   // Keywords are right justified: byte j holds the j-th character counted
   // back from the last one.
   localparam logic [8*KEY_MAX_LEN-1:0] KEY_TEXT [NUM_KEYS] = '{
      "did you know", "apparently",
      "?",
      "asap", "emergency", "need help", "urgent",
      "sad", "angry", "happy", "excited", "frustrated", "worried", "anxious",
      "love", "hate", "miss",
      "when", "where", "let's", "should we",
      "lol", "haha", "lmao", "hahaha"
   };
   localparam int KEY_LEN [NUM_KEYS] = '{
      12, 10, 1, 4, 9, 9, 6, 3, 5, 5, 7, 10, 7, 7, 4, 4, 4, 4, 5, 5, 9, 3, 4, 4, 6
   };
   localparam group_type KEY_GROUP [NUM_KEYS] = '{
      GROUP_INFO, GROUP_INFO,
      GROUP_QUESTION,
      GROUP_URGENT, GROUP_URGENT, GROUP_URGENT, GROUP_URGENT,
      GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL,
      GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL,
      GROUP_EMOTIONAL, GROUP_EMOTIONAL,
      GROUP_PLANNING, GROUP_PLANNING, GROUP_PLANNING, GROUP_PLANNING,
      GROUP_HUMOR, GROUP_HUMOR, GROUP_HUMOR, GROUP_HUMOR
   };

   function automatic logic [7:0] fold(input logic [7:0] value);
      return value | FOLD_BIT;
   endfunction

endpackage

// ===== hw/rtl/kmc_hist_cell.sv =====
module kmc_hist_cell
   import kmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    prev_byte,
   input  logic          prev_valid,
   output logic [7:0]    cell_byte,
   output logic          cell_valid
);

   logic [7:0] byte_ff, byte_in;
   logic       valid_ff, valid_in;

   // A clear wins over a shift: the last byte of a message is never kept.
   always_comb begin
      byte_in  = ctrl.shift ? prev_byte : byte_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign cell_byte  = byte_ff;
   assign cell_valid = valid_ff;

endmodule

// ===== hw/rtl/kmc_keyword_match.sv =====
module kmc_keyword_match
   import kmc_pkg::*;
(
   input  logic [7:0]                    cur_byte,
   input  logic [HISTORY_DEPTH-1:0][7:0] hist_byte,
   input  logic [HISTORY_DEPTH-1:0]      hist_valid,
   output logic [NUM_GROUPS-1:0]         group_hits
);

   // Every keyword is compared in parallel against the current byte and the
   // newest history cells; a cell that holds no byte of this message blocks it.
   always_comb begin
      logic hit;
      group_hits = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         hit = (fold(KEY_TEXT[k][7:0]) == cur_byte);
         for (int j = 1; j < KEY_MAX_LEN; j++) begin
            if (j < KEY_LEN[k]) begin
               hit = hit && hist_valid[j-1]
                     && (hist_byte[j-1] == fold(KEY_TEXT[k][8*j +: 8]));
            end
         end
         if (hit) begin
            group_hits[KEY_GROUP[k]] = 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/keyword_message_classifier_core.sv =====
// Keyword message classifier.
//
// A message enters on the request channel one byte per request, with
// has_byte marking a real byte and end_of_message flagging the final
// request (a bare end request with has_byte low is allowed). Each byte is
// case-folded and shifted into a chain of history cells; all keyword and
// greeting-prefix compares run on the chain in parallel, so one request is
// taken every clock cycle with no gaps between messages, unless stalled.
// On the end request one response carries the class code and confidence in
// percent. It appears in the response register on the cycle after the end
// request is accepted and stays there until taken. Requests without the end
// flag keep flowing while a response waits; only an end request is stalled,
// and only while the response register is full and the receiver stalls it.
// Reset clears the history cells, byte count and hit flags and empties the
// response register; the block is ready for a request right after reset.
// The same clearing happens after every end request.
module keyword_message_classifier_core
   import kmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic [HISTORY_DEPTH-1:0][7:0] hist_byte;
   logic [HISTORY_DEPTH-1:0]      hist_valid;
   cell_ctrl_type                 cell_ctrl;

   logic [3:0]            count_ff, count_in, count_upd;
   logic [NUM_PREFIX-1:0] alive_ff, alive_in, alive_calc, alive_upd;
   logic                  greet_ff, greet_in, greet_calc, greet_upd;
   logic [NUM_GROUPS-1:0] group_ff, group_in, group_upd, key_hits;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in, rsp_calc;

   logic       req_accept, end_accept;
   logic [7:0] cur_byte;

   // Only an end request needs the response register.
   assign req_stall  = req_payload.end_of_message && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign end_accept = req_accept && req_payload.end_of_message;
   assign cur_byte   = fold(req_payload.msg_byte);

   assign cell_ctrl.shift = req_accept && req_payload.has_byte;
   assign cell_ctrl.clear = end_accept;

   // History chain: cell 0 takes the current folded byte, each later cell
   // takes its neighbor's byte on every shift.
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         kmc_hist_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .prev_byte  (cur_byte),
            .prev_valid (1'b1),
            .cell_byte  (hist_byte[i]),
            .cell_valid (hist_valid[i])
         );
      end else begin : g_body
         kmc_hist_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .prev_byte  (hist_byte[i-1]),
            .prev_valid (hist_valid[i-1]),
            .cell_byte  (hist_byte[i]),
            .cell_valid (hist_valid[i])
         );
      end
   end

   kmc_keyword_match u_match (
      .cur_byte   (cur_byte),
      .hist_byte  (hist_byte),
      .hist_valid (hist_valid),
      .group_hits (key_hits)
   );

   // Greeting prefixes are tracked by byte position. A prefix drops out at
   // its first mismatch; matching its last character raises the greeting flag.
   always_comb begin
      alive_calc = alive_ff;
      greet_calc = greet_ff;
      for (int p = 0; p < NUM_PREFIX; p++) begin
         if ((count_ff < PREFIX_LEN[p]) && alive_ff[p]) begin
            if (PREFIX_CHAR[p][count_ff[2:0]] != cur_byte) begin
               alive_calc[p] = 1'b0;
            end else if (count_ff == PREFIX_LEN[p] - 1) begin
               greet_calc = 1'b1;
            end
         end
      end
   end

   // Message state as it stands after the current request's byte.
   always_comb begin
      if (req_payload.has_byte) begin
         count_upd = (count_ff == COUNT_MAX) ? count_ff : count_ff + 4'd1;
         alive_upd = alive_calc;
         greet_upd = greet_calc;
         group_upd = group_ff | key_hits;
      end else begin
         count_upd = count_ff;
         alive_upd = alive_ff;
         greet_upd = greet_ff;
         group_upd = group_ff;
      end
   end

   always_comb begin
      if (end_accept) begin
         count_in = '0;
         alive_in = '1;
         greet_in = 1'b0;
         group_in = '0;
      end else if (req_accept) begin
         count_in = count_upd;
         alive_in = alive_upd;
         greet_in = greet_upd;
         group_in = group_upd;
      end else begin
         count_in = count_ff;
         alive_in = alive_ff;
         greet_in = greet_ff;
         group_in = group_ff;
      end
   end

   // Class in priority order: unknown for an empty message, then greeting, then
   // the keyword groups in their fixed order, with casual when nothing else hit.
   always_comb begin
      rsp_calc.class_code     = CLASS_CASUAL;
      rsp_calc.confidence_pct = CONF_CASUAL;
      if (count_upd == 4'd0) begin
         rsp_calc.class_code     = CLASS_UNKNOWN;
         rsp_calc.confidence_pct = CONF_UNKNOWN;
      end else if (greet_upd) begin
         rsp_calc.class_code     = CLASS_GREETING;
         rsp_calc.confidence_pct = CONF_DEFAULT;
      end else if (group_upd[GROUP_INFO]) begin
         rsp_calc.class_code     = CLASS_INFO;
         rsp_calc.confidence_pct = CONF_DEFAULT;
      end else if (group_upd[GROUP_QUESTION]) begin
         rsp_calc.class_code     = CLASS_QUESTION;
         rsp_calc.confidence_pct = CONF_DEFAULT;
      end else if (group_upd[GROUP_URGENT]) begin
         rsp_calc.class_code     = CLASS_URGENT;
         rsp_calc.confidence_pct = CONF_DEFAULT;
      end else if (group_upd[GROUP_EMOTIONAL]) begin
         rsp_calc.class_code     = CLASS_EMOTIONAL;
         rsp_calc.confidence_pct = CONF_EMOTIONAL;
      end else if (group_upd[GROUP_PLANNING]) begin
         rsp_calc.class_code     = CLASS_PLANNING;
         rsp_calc.confidence_pct = CONF_DEFAULT;
      end else if (group_upd[GROUP_HUMOR]) begin
         rsp_calc.class_code     = CLASS_HUMOR;
         rsp_calc.confidence_pct = CONF_DEFAULT;
      end
   end

   // Response register: holds while stalled, loads on an accepted end request.
   always_comb begin
      rsp_in = end_accept ? rsp_calc : rsp_ff;
      if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = end_accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         count_ff     <= '0;
         alive_ff     <= '1;
         greet_ff     <= 1'b0;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         alive_ff     <= alive_in;
         greet_ff     <= greet_in;
         group_ff     <= group_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An accepted end request always leaves a response behind.
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      end_accept |=> rsp_valid_ff)
      else $error("end request accepted without a response");

   // Message state is cleared after every end request.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      end_accept |=> (count_ff == 4'd0) && (alive_ff == '1) && !greet_ff
                     && (group_ff == '0) && !hist_valid[0])
      else $error("message state not cleared after end request");

   // The newest history cell holds a byte exactly when the message has one.
   a_head_cell_count: assert property (@(posedge clock) disable iff (reset)
      hist_valid[0] == (count_ff != 4'd0))
      else $error("history head disagrees with byte count");

   // Hits can only come from bytes of the current message.
   a_hits_need_bytes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 4'd0) |-> (!greet_ff && (group_ff == '0)))
      else $error("hit flags set on an empty message");

   // A waiting, stalled response is never overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && (rsp_ff == $past(rsp_ff)))
      else $error("stalled response changed");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import kmc_pkg::*;

   // Own copy of the classifier tables. Keywords and prefixes are right
   // justified, so byte j of an entry is the j-th character counted back
   // from its last one.
   localparam int HIST_LEN      = 11;
   localparam int KEY_COUNT     = 25;
   localparam int GREET_COUNT   = 5;
   localparam logic [7:0] CASE_BIT  = 8'h20;
   localparam logic [3:0] SEEN_LIMIT = 4'd15;

   localparam logic [6:0] PCT_NONE    = 7'd0;
   localparam logic [6:0] PCT_USUAL   = 7'd80;
   localparam logic [6:0] PCT_FEELING = 7'd75;
   localparam logic [6:0] PCT_CHAT    = 7'd60;

   localparam logic [95:0] KEY_WORDS [KEY_COUNT] = '{
      "did you know", "apparently",
      "?",
      "asap", "emergency", "need help", "urgent",
      "sad", "angry", "happy", "excited", "frustrated", "worried", "anxious",
      "love", "hate", "miss",
      "when", "where", "let's", "should we",
      "lol", "haha", "lmao", "hahaha"
   };
   localparam int KEY_LENGTHS [KEY_COUNT] = '{
      12, 10, 1, 4, 9, 9, 6, 3, 5, 5, 7, 10, 7, 7, 4, 4, 4, 4, 5, 5, 9, 3, 4, 4, 6
   };
   localparam group_type KEY_GROUPS [KEY_COUNT] = '{
      GROUP_INFO, GROUP_INFO,
      GROUP_QUESTION,
      GROUP_URGENT, GROUP_URGENT, GROUP_URGENT, GROUP_URGENT,
      GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL,
      GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL, GROUP_EMOTIONAL,
      GROUP_EMOTIONAL, GROUP_EMOTIONAL,
      GROUP_PLANNING, GROUP_PLANNING, GROUP_PLANNING, GROUP_PLANNING,
      GROUP_HUMOR, GROUP_HUMOR, GROUP_HUMOR, GROUP_HUMOR
   };
   localparam logic [39:0] GREETINGS [GREET_COUNT] = '{"hey", "hi", "hello", "yo", "sup"};
   localparam int GREETING_LENGTHS [GREET_COUNT] = '{3, 2, 5, 2, 3};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Shadow of the message state: folded bytes (newest first), how many
   // bytes were taken, which greeting prefixes still match, and the sticky
   // greeting and keyword group flags.
   logic [7:0] folded_history [HIST_LEN];
   logic [3:0] seen_count;
   logic [4:0] prefix_live;
   logic       greeted;
   logic [5:0] group_flags;

   // Class and confidence predicted for every accepted end request, oldest first.
   rsp_type expected_replies [$];
   rsp_type want_reply;

   // The message under construction in the random part.
   logic [7:0] draft_msg [$];

   int  mismatches    = 0;
   int  requests_sent = 0;
   bit  req_jitter    = 1'b0;
   bit  rsp_jitter    = 1'b0;
   int  hold_request  = 0;

   keyword_message_classifier_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   task automatic clear_message();
      for (int i = 0; i < HIST_LEN; i++) folded_history[i] = 8'h00;
      seen_count  = 4'd0;
      prefix_live = 5'h1F;
      greeted     = 1'b0;
      group_flags = 6'h00;
   endtask

   // Takes one message byte: greeting prefixes are checked against the byte
   // position, and every keyword is checked for ending on this byte.
   task automatic absorb_byte(input logic [7:0] raw);
      logic [7:0] cur;
      logic [7:0] ch;
      int         pos;
      bit         hit;
      cur = raw | CASE_BIT;
      pos = int'(seen_count);
      for (int p = 0; p < GREET_COUNT; p++) begin
         if (pos < GREETING_LENGTHS[p] && prefix_live[p]) begin
            ch = GREETINGS[p][8*(GREETING_LENGTHS[p]-1-pos) +: 8] | CASE_BIT;
            if (ch != cur) begin
               prefix_live[p] = 1'b0;
            end else if (pos == GREETING_LENGTHS[p] - 1) begin
               greeted = 1'b1;
            end
         end
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
         // A keyword longer than the bytes taken so far, this one included,
         // cannot match; history beyond the count is never looked at.
         if (KEY_LENGTHS[k] <= pos + 1) begin
            hit = ((KEY_WORDS[k][7:0] | CASE_BIT) == cur);
            for (int j = 1; j < KEY_LENGTHS[k]; j++) begin
               if ((KEY_WORDS[k][8*j +: 8] | CASE_BIT) != folded_history[j-1]) hit = 1'b0;
            end
            if (hit) group_flags[KEY_GROUPS[k]] = 1'b1;
         end
      end
      for (int i = HIST_LEN - 1; i > 0; i--) folded_history[i] = folded_history[i-1];
      folded_history[0] = cur;
      if (seen_count < SEEN_LIMIT) seen_count = seen_count + 4'd1;
   endtask

   // Applies one accepted request; an end request queues the class that the
   // message earned, in priority order, and starts a fresh message.
   task automatic classify_request(input req_type r);
      rsp_type reply;
      if (r.has_byte) absorb_byte(r.msg_byte);
      if (r.end_of_message) begin
         if (seen_count == 4'd0) begin
            reply.class_code = CLASS_UNKNOWN;   reply.confidence_pct = PCT_NONE;
         end else if (greeted) begin
            reply.class_code = CLASS_GREETING;  reply.confidence_pct = PCT_USUAL;
         end else if (group_flags[GROUP_INFO]) begin
            reply.class_code = CLASS_INFO;      reply.confidence_pct = PCT_USUAL;
         end else if (group_flags[GROUP_QUESTION]) begin
            reply.class_code = CLASS_QUESTION;  reply.confidence_pct = PCT_USUAL;
         end else if (group_flags[GROUP_URGENT]) begin
            reply.class_code = CLASS_URGENT;    reply.confidence_pct = PCT_USUAL;
         end else if (group_flags[GROUP_EMOTIONAL]) begin
            reply.class_code = CLASS_EMOTIONAL; reply.confidence_pct = PCT_FEELING;
         end else if (group_flags[GROUP_PLANNING]) begin
            reply.class_code = CLASS_PLANNING;  reply.confidence_pct = PCT_USUAL;
         end else if (group_flags[GROUP_HUMOR]) begin
            reply.class_code = CLASS_HUMOR;     reply.confidence_pct = PCT_USUAL;
         end else begin
            reply.class_code = CLASS_CASUAL;    reply.confidence_pct = PCT_CHAT;
         end
         expected_replies.push_back(reply);
         clear_message();
      end
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Idle cycles before the next request: mostly none, sometimes a few,
   // now and then a long pause. With jitter off requests go back to back.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (!req_jitter || r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offers one request at the falling edge and holds it until the block
   // takes it at a rising edge with req_stall low. Valid stays high when the
   // next request follows without a gap.
   task automatic send_request(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_request(item);
      if (item.has_byte || item.end_of_message) requests_sent++;
   endtask

   task automatic send_bare(input bit end_flag);
      req_type item;
      item.msg_byte       = 8'($urandom_range(0, 255));
      item.has_byte       = 1'b0;
      item.end_of_message = end_flag;
      send_request(item);
   endtask

   task automatic send_byte(input logic [7:0] value, input bit end_flag);
      req_type item;
      item.msg_byte       = value;
      item.has_byte       = 1'b1;
      item.end_of_message = end_flag;
      send_request(item);
   endtask

   task automatic send_text(input string text, input bit end_on_last);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], end_on_last && i == text.len() - 1);
   endtask

   // Appends the first n characters of a right-justified word to the draft,
   // clearing bit 5 at random: folding brings every such byte back.
   task automatic append_chars(input logic [95:0] word, input int len, input int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         c = word[8*(len-1-i) +: 8];
         if ($urandom_range(0, 3) == 0) c[5] = 1'b0;
         draft_msg.push_back(c);
      end
   endtask

   // Builds and sends one message: an optional greeting prefix, then a few
   // segments of keywords (some cut short), letter filler, raw bytes and
   // long runs that saturate the byte count. Stray ignored requests fall in
   // between, and the end comes either on the last byte or as a bare end.
   task automatic send_random_message();
      int segs;
      int choice;
      int k;
      int n;
      bit bare_end;
      draft_msg.delete();
      segs     = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      bare_end = ($urandom_range(0, 3) == 0);
      if (segs > 0 && $urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, GREET_COUNT - 1);
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, GREETING_LENGTHS[k])
                                         : GREETING_LENGTHS[k];
         append_chars(GREETINGS[k], GREETING_LENGTHS[k], n);
      end
      for (int s = 0; s < segs && draft_msg.size() < 24; s++) begin
         choice = $urandom_range(0, 9);
         if (choice < 5) begin
            k = $urandom_range(0, KEY_COUNT - 1);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, KEY_LENGTHS[k]) : KEY_LENGTHS[k];
            append_chars(KEY_WORDS[k], KEY_LENGTHS[k], n);
         end else if (choice < 7 || choice == 9) begin
            n = (choice == 9) ? $urandom_range(10, 16) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               k = $urandom_range(0, 26);
               draft_msg.push_back(k == 0 ? 8'h20 : 8'h60 + k[7:0]);
            end
         end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) draft_msg.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (int i = 0; i < draft_msg.size(); i++) begin
         if ($urandom_range(0, 15) == 0) send_bare(1'b0);
         send_byte(draft_msg[i], !bare_end && i == draft_msg.size() - 1);
      end
      if (bare_end || draft_msg.size() == 0) send_bare(1'b1);
   endtask

   // Drops valid, waits until every predicted class has come back, and then
   // waits on for any response still on its way.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // The receiver stalls at the falling edge. A long hold-off asked for by
   // the back-pressure test is counted out here; otherwise, with jitter on,
   // short stalls dominate and a few long ones fall in.
   initial begin : rsp_stall_driver
      int n;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
            rsp_stall <= 1'b0;
         end else if (rsp_jitter && $urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every response taken is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: response with none expected: class_code %0d confidence_pct %0d",
                     $time, rsp_payload.class_code, rsp_payload.confidence_pct);
            mismatches++;
         end else begin
            want_reply = expected_replies.pop_front();
            if (rsp_payload.class_code !== want_reply.class_code) begin
               $display("%0t: class_code expected %0d actual %0d",
                        $time, want_reply.class_code, rsp_payload.class_code);
               mismatches++;
            end
            if (rsp_payload.confidence_pct !== want_reply.confidence_pct) begin
               $display("%0t: confidence_pct expected %0d actual %0d",
                        $time, want_reply.confidence_pct, rsp_payload.confidence_pct);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty message, ignored bare requests, a greeting closed by a bare end,
   // and the longest greeting prefix closed on its last byte.
   task automatic test_empty_and_bare();
      send_bare(1'b1);
      send_bare(1'b0);
      send_text("Yo", 1'b0);
      send_bare(1'b1);
      send_text("hello", 1'b1);
   endtask

   // Folding is a plain OR with 0x20: 0x1F reads as a question mark, 0x00
   // as a space, and upper case matches lower case keywords.
   task automatic test_case_folding();
      send_byte(8'h1F, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_text("ASAP", 1'b1);
   endtask

   // Priority between classes: question over humor, emotional on its own
   // at its lower confidence, greeting over question.
   task automatic test_priority();
      send_text("lol?", 1'b1);
      send_text("Sad", 1'b1);
      send_text("hi?", 1'b1);
   endtask

   // Random messages with jitter switched on and off in stretches, so that
   // both idle patterns and runs of back-to-back traffic occur.
   task automatic test_random_traffic();
      int first;
      int msgs;
      first = requests_sent;
      msgs  = 0;
      while (requests_sent - first < 800) begin
         if (msgs % 12 == 0) begin
            req_jitter = ($urandom_range(0, 3) != 0);
            rsp_jitter = ($urandom_range(0, 3) != 0);
         end
         send_random_message();
         msgs++;
      end
      req_jitter = 1'b0;
      rsp_jitter = 1'b0;
   endtask

   // The receiver holds off for a long stretch while short messages keep
   // arriving back to back; the second end request must be stalled until
   // the pending response is taken.
   task automatic test_backpressure();
      hold_request = 200;
      for (int m = 0; m < 20; m++) begin
         if (m % 2 == 0) send_text("lol", 1'b1);
         else send_text("when?", 1'b1);
      end
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      clear_message();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_bare();
      test_case_folding();
      test_priority();
      wait_idle();
      test_random_traffic();
      wait_idle();
      test_backpressure();
      wait_idle();

      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Far beyond the slowest legal run: every request behind a long gap,
   // every response behind a long stall, and the long hold-off.
   initial begin : watchdog
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== keyword_message_classifier_core.f =====
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_hist_cell.sv
hw/rtl/kmc_keyword_match.sv
hw/rtl/keyword_message_classifier_core.sv
verif/tb.sv
